### rtl/core/lsms_pkg.sv
// Shared types, constants and microcode encodings for the LCG mean/stddev block.
`timescale 1ns / 1ps
`default_nettype none

package lsms_pkg;

    localparam int W_X         = 24;            // generator value, config words
    localparam int W_N         = 15;            // sample count
    localparam int FRAC_BITS   = 24;            // fraction bits of the results
    localparam int MAX_SAMPLES = 16384;
    localparam int W_PROD      = 2 * W_X + 1;   // a*x + c
    localparam int W_S1        = 38;            // sum of x
    localparam int W_S2        = 62;            // sum of x*x
    localparam int W_V         = 76;            // divisor: m, n*m or (n*m)^2
    localparam int W_ACC       = W_V + 1;       // remainder / product accumulator
    localparam int W_Q         = 2 * FRAC_BITS; // quotient shift register
    localparam int W_IT        = 6;             // repeat counter
    localparam int W_PC        = 5;             // microcode address
    localparam int W_CFG_IDX   = 2;

    localparam logic [W_CFG_IDX-1:0] REG_MULT = 2'd0;
    localparam logic [W_CFG_IDX-1:0] REG_INCR = 2'd1;
    localparam logic [W_CFG_IDX-1:0] REG_MODU = 2'd2;

    localparam logic [W_X-1:0] RST_MULT = 24'd1366;
    localparam logic [W_X-1:0] RST_INCR = 24'd150889;
    localparam logic [W_X-1:0] RST_MODU = 24'd714025;

    // repeat counts, loaded as count minus one
    localparam logic [W_IT-1:0] IT_MOD  = W_IT'(W_PROD - 1);
    localparam logic [W_IT-1:0] IT_MEAN = W_IT'(FRAC_BITS - 1);
    localparam logic [W_IT-1:0] IT_SQR  = W_IT'(W_S1 - 1);
    localparam logic [W_IT-1:0] IT_NS2  = W_IT'(W_N - 1);
    localparam logic [W_IT-1:0] IT_VAR  = W_IT'(2 * FRAC_BITS - 1);
    localparam logic [W_IT-1:0] IT_ROOT = W_IT'(FRAC_BITS - 1);

    // program addresses that are jump targets
    localparam logic [W_PC-1:0] A_IDLE  = 5'd0;
    localparam logic [W_PC-1:0] A_LOOP  = 5'd4;
    localparam logic [W_PC-1:0] A_EMPTY = 5'd21;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_START,
        OP_LCGMUL,
        OP_DIV,
        OP_SETX,
        OP_ACC,
        OP_DEN,
        OP_MEAN,
        OP_MACADD,
        OP_MVDEN2,
        OP_MACSUB,
        OP_LDNS2,
        OP_VARSET,
        OP_SQSET,
        OP_SQSTEP,
        OP_OUT,
        OP_OUTEMPTY
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_START,
        J_REPEAT,
        J_ZERO,
        J_LOOP,
        J_OUT,
        J_GOTO
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_jmp            jmp;
        logic [W_PC-1:0] target;
        logic            ld_iter;
        logic [W_IT-1:0] iter_val;
    } t_uword;

    typedef struct packed {
        logic [W_X-1:0] mult;
        logic [W_X-1:0] incr;
        logic [W_X-1:0] modu;
    } t_cfg;

    typedef struct packed {
        logic n_zero;   // saturated count is zero
        logic last;     // sample being summed is the final one
    } t_status;

endpackage

`default_nettype wire

### rtl/core/lsms_ucode_rom.sv
// Microcode program: one control word per step.
`timescale 1ns / 1ps
`default_nettype none

module lsms_ucode_rom (
    input  wire logic [lsms_pkg::W_PC-1:0] i_addr,
    output lsms_pkg::t_uword               o_uword
);
    import lsms_pkg::*;

    function automatic t_uword uw(t_op op, t_jmp jmp, logic [W_PC-1:0] target,
                                  logic ld, logic [W_IT-1:0] iv);
        t_uword w;
        w.op       = op;
        w.jmp      = jmp;
        w.target   = target;
        w.ld_iter  = ld;
        w.iter_val = iv;
        return w;
    endfunction

    always_comb begin
        case (i_addr)
            // wait for an item
            5'd0:    o_uword = uw(OP_START,    J_START,  A_IDLE,  1'b0, '0);
            // discarded first step
            5'd1:    o_uword = uw(OP_LCGMUL,   J_NEXT,   A_IDLE,  1'b1, IT_MOD);
            5'd2:    o_uword = uw(OP_DIV,      J_REPEAT, A_IDLE,  1'b0, '0);
            5'd3:    o_uword = uw(OP_SETX,     J_ZERO,   A_EMPTY, 1'b0, '0);
            // sample loop
            5'd4:    o_uword = uw(OP_LCGMUL,   J_NEXT,   A_IDLE,  1'b1, IT_MOD);
            5'd5:    o_uword = uw(OP_DIV,      J_REPEAT, A_IDLE,  1'b0, '0);
            5'd6:    o_uword = uw(OP_SETX,     J_NEXT,   A_IDLE,  1'b0, '0);
            5'd7:    o_uword = uw(OP_ACC,      J_LOOP,   A_LOOP,  1'b0, '0);
            // mean = S1 * 2^F / (n*m)
            5'd8:    o_uword = uw(OP_DEN,      J_NEXT,   A_IDLE,  1'b1, IT_MEAN);
            5'd9:    o_uword = uw(OP_DIV,      J_REPEAT, A_IDLE,  1'b0, '0);
            // (n*m)^2
            5'd10:   o_uword = uw(OP_MEAN,     J_NEXT,   A_IDLE,  1'b1, IT_SQR);
            5'd11:   o_uword = uw(OP_MACADD,   J_REPEAT, A_IDLE,  1'b0, '0);
            // n*S2 - S1^2
            5'd12:   o_uword = uw(OP_MVDEN2,   J_NEXT,   A_IDLE,  1'b1, IT_SQR);
            5'd13:   o_uword = uw(OP_MACSUB,   J_REPEAT, A_IDLE,  1'b0, '0);
            5'd14:   o_uword = uw(OP_LDNS2,    J_NEXT,   A_IDLE,  1'b1, IT_NS2);
            5'd15:   o_uword = uw(OP_MACADD,   J_REPEAT, A_IDLE,  1'b0, '0);
            // scaled variance quotient, then its root
            5'd16:   o_uword = uw(OP_VARSET,   J_NEXT,   A_IDLE,  1'b1, IT_VAR);
            5'd17:   o_uword = uw(OP_DIV,      J_REPEAT, A_IDLE,  1'b0, '0);
            5'd18:   o_uword = uw(OP_SQSET,    J_NEXT,   A_IDLE,  1'b1, IT_ROOT);
            5'd19:   o_uword = uw(OP_SQSTEP,   J_REPEAT, A_IDLE,  1'b0, '0);
            5'd20:   o_uword = uw(OP_OUT,      J_OUT,    A_IDLE,  1'b0, '0);
            5'd21:   o_uword = uw(OP_OUTEMPTY, J_OUT,    A_IDLE,  1'b0, '0);
            default: o_uword = uw(OP_NOP,      J_GOTO,   A_IDLE,  1'b0, '0);
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lsms_seq.sv
// Microcode sequencer: step counter, repeat counter and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module lsms_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_free,
    input  wire lsms_pkg::t_status i_status,
    output lsms_pkg::t_op          o_op,
    output logic                   o_in_ready
);
    import lsms_pkg::*;

    logic [W_PC-1:0] r_pc, n_pc;
    logic [W_IT-1:0] r_iter, n_iter;
    logic [W_PC-1:0] w_pc_inc;
    t_uword          w_uw;

    lsms_ucode_rom u_rom (
        .i_addr  (r_pc),
        .o_uword (w_uw)
    );

    assign w_pc_inc   = r_pc + 5'd1;
    assign o_op       = w_uw.op;
    assign o_in_ready = (r_pc == A_IDLE);

    always_comb begin
        n_pc = w_pc_inc;
        case (w_uw.jmp)
            J_NEXT:   n_pc = w_pc_inc;
            J_START:  n_pc = i_in_valid ? w_pc_inc : r_pc;
            J_REPEAT: n_pc = (r_iter != '0) ? r_pc : w_pc_inc;
            J_ZERO:   n_pc = i_status.n_zero ? w_uw.target : w_pc_inc;
            J_LOOP:   n_pc = i_status.last ? w_pc_inc : w_uw.target;
            J_OUT:    n_pc = i_out_free ? w_uw.target : r_pc;
            J_GOTO:   n_pc = w_uw.target;
            default:  n_pc = A_IDLE;
        endcase
    end

    always_comb begin
        n_iter = r_iter;
        if (w_uw.ld_iter) begin
            n_iter = w_uw.iter_val;
        end else if (w_uw.jmp == J_REPEAT && r_iter != '0) begin
            n_iter = r_iter - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= A_IDLE;
            r_iter <= '0;
        end else begin
            r_pc   <= n_pc;
            r_iter <= n_iter;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lsms_datapath.sv
// Datapath: generator, running sums, shared multiplier and bit-serial units.
`timescale 1ns / 1ps
`default_nettype none

module lsms_datapath (
    input  wire logic                     i_clk,
    input  wire lsms_pkg::t_op            i_op,
    input  wire lsms_pkg::t_cfg           i_cfg,
    input  wire logic [lsms_pkg::W_X-1:0] i_seed,
    input  wire logic [lsms_pkg::W_N-1:0] i_sample_count,
    output lsms_pkg::t_status             o_status,
    output logic [lsms_pkg::W_X-1:0]      o_mean,
    output logic [lsms_pkg::W_X-1:0]      o_stddev
);
    import lsms_pkg::*;

    logic [W_X-1:0]   r_x, n_x;
    logic [W_N-1:0]   r_n, n_n;
    logic [W_N-1:0]   r_cnt, n_cnt;
    logic [W_S1-1:0]  r_s1, n_s1;
    logic [W_S2-1:0]  r_s2, n_s2;
    logic [W_ACC-1:0] r_rem, n_rem;   // remainder, accumulator, root operand
    logic [W_V-1:0]   r_v, n_v;       // divisor
    logic [W_ACC-1:0] r_mc, n_mc;     // multiplicand / dividend bits / root bit
    logic [W_S1-1:0]  r_mp, n_mp;     // multiplier bits
    logic [W_Q-1:0]   r_q, n_q;       // quotient / root
    logic [W_X-1:0]   r_mean, n_mean;

    logic [W_X-1:0]   w_m_eff;
    logic [W_N-1:0]   w_n_sat;
    logic [W_X-1:0]   w_mul_a, w_mul_b;
    logic [2*W_X-1:0] w_prod;
    logic [W_ACC-1:0] w_div_sh;
    logic             w_div_ge;
    logic [W_ACC-1:0] w_mac_add;
    logic [W_Q:0]     w_sq_t;
    logic             w_sq_ge;

    assign w_m_eff = (i_cfg.modu < 24'd2) ? 24'd2 : i_cfg.modu;
    assign w_n_sat = (i_sample_count > W_N'(MAX_SAMPLES)) ? W_N'(MAX_SAMPLES)
                                                          : i_sample_count;

    // one shared 24x24 multiplier
    always_comb begin
        case (i_op)
            OP_LCGMUL: begin
                w_mul_a = i_cfg.mult;
                w_mul_b = r_x;
            end
            OP_DEN: begin
                w_mul_a = W_X'(r_n);
                w_mul_b = w_m_eff;
            end
            default: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // restoring division step; the remainder stays below the divisor
    assign w_div_sh  = {r_rem[W_ACC-2:0], r_mc[W_PROD-1]};
    assign w_div_ge  = (w_div_sh >= {1'b0, r_v});
    assign w_mac_add = r_mp[0] ? r_mc : '0;

    // square root step
    assign w_sq_t  = {1'b0, r_q} + {1'b0, r_mc[W_Q-1:0]};
    assign w_sq_ge = ({1'b0, r_rem[W_Q-1:0]} >= w_sq_t);

    always_comb begin
        n_x    = r_x;
        n_n    = r_n;
        n_cnt  = r_cnt;
        n_s1   = r_s1;
        n_s2   = r_s2;
        n_rem  = r_rem;
        n_v    = r_v;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_q    = r_q;
        n_mean = r_mean;
        case (i_op)
            OP_START: begin
                n_x   = i_seed;
                n_n   = w_n_sat;
                n_cnt = '0;
                n_s1  = '0;
                n_s2  = '0;
            end
            OP_LCGMUL: begin
                n_mc  = W_ACC'(W_PROD'(w_prod) + W_PROD'(i_cfg.incr));
                n_v   = W_V'(w_m_eff);
                n_rem = '0;
            end
            OP_DIV: begin
                n_rem = w_div_ge ? (w_div_sh - {1'b0, r_v}) : w_div_sh;
                n_q   = {r_q[W_Q-2:0], w_div_ge};
                n_mc  = r_mc << 1;
            end
            OP_SETX: begin
                n_x = r_rem[W_X-1:0];
            end
            OP_ACC: begin
                n_s1  = r_s1 + W_S1'(r_x);
                n_s2  = r_s2 + W_S2'(w_prod);
                n_cnt = r_cnt + 15'd1;
            end
            OP_DEN: begin
                n_v   = W_V'(w_prod[W_S1-1:0]);
                n_rem = W_ACC'(r_s1);
                n_mc  = '0;
                n_q   = '0;
            end
            OP_MEAN: begin
                n_mean = r_q[W_X-1:0];
                n_mc   = W_ACC'(r_v);
                n_mp   = r_v[W_S1-1:0];
                n_rem  = '0;
            end
            OP_MACADD: begin
                n_rem = r_rem + w_mac_add;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
            end
            OP_MVDEN2: begin
                n_v   = r_rem[W_V-1:0];
                n_rem = '0;
                n_mc  = W_ACC'(r_s1);
                n_mp  = r_s1;
            end
            OP_MACSUB: begin
                n_rem = r_rem - w_mac_add;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
            end
            OP_LDNS2: begin
                n_mc = W_ACC'(r_s2);
                n_mp = W_S1'(r_n);
            end
            OP_VARSET: begin
                n_mc = '0;
                n_q  = '0;
            end
            OP_SQSET: begin
                n_rem          = W_ACC'(r_q);
                n_q            = '0;
                n_mc           = '0;
                n_mc[W_Q-2]    = 1'b1;
            end
            OP_SQSTEP: begin
                if (w_sq_ge) begin
                    n_rem = W_ACC'(r_rem[W_Q-1:0] - w_sq_t[W_Q-1:0]);
                    n_q   = (r_q >> 1) + r_mc[W_Q-1:0];
                end else begin
                    n_q   = r_q >> 1;
                end
                n_mc = r_mc >> 2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_rem  <= n_rem;
        r_v    <= n_v;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_q    <= n_q;
        r_mean <= n_mean;
    end

    assign o_status.n_zero = (r_n == '0);
    assign o_status.last   = ((r_cnt + 15'd1) == r_n);
    assign o_mean          = r_mean;
    assign o_stddev        = r_q[W_X-1:0];

endmodule

`default_nettype wire

### rtl/core/lcg_sample_mean_stddev.sv
// Top level: config registers, microcoded core and result register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid  / o_in_ready    | i_seed, i_sample_count
//  out     | out       | o_out_valid / i_out_ready   | o_mean_q24, o_stddev_q24, o_empty_error
//
// The sample count saturates at 16384. Each generator step reduces a*x + c by the
// modulus with a restoring division, one remainder bit per cycle, and the closing
// arithmetic follows the last sample; a zero count skips to the empty result.
// Synchronous active-low reset restores the register defaults and parks the
// sequencer at its idle step. A stalled result waits in the output register while
// the next item is accepted and run; the program only stalls when a new result
// is ready and the previous one has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module lcg_sample_mean_stddev (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lsms_pkg::W_CFG_IDX-1:0] i_cfg_index,
    input  wire logic [lsms_pkg::W_X-1:0]       i_cfg_data,
    // start items
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lsms_pkg::W_X-1:0]       i_seed,
    input  wire logic [lsms_pkg::W_N-1:0]       i_sample_count,
    // result items
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [lsms_pkg::W_X-1:0]            o_mean_q24,
    output logic [lsms_pkg::W_X-1:0]            o_stddev_q24,
    output logic                                o_empty_error
);
    import lsms_pkg::*;

    t_cfg           r_cfg;
    t_op            w_op;
    t_status        w_status;
    logic [W_X-1:0] w_mean, w_stddev;
    logic           w_out_free;
    logic           w_out_load;

    // config writes always land; the user must write them only while the block is idle, which it does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mult <= RST_MULT;
            r_cfg.incr <= RST_INCR;
            r_cfg.modu <= RST_MODU;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MULT: r_cfg.mult <= i_cfg_data;
                REG_INCR: r_cfg.incr <= i_cfg_data;
                REG_MODU: r_cfg.modu <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output slot is free when empty or being drained this cycle
    assign w_out_free = !o_out_valid || i_out_ready;

    lsms_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_op       (w_op),
        .o_in_ready (o_in_ready)
    );

    lsms_datapath u_dp (
        .i_clk          (i_clk),
        .i_op           (w_op),
        .i_cfg          (r_cfg),
        .i_seed         (i_seed),
        .i_sample_count (i_sample_count),
        .o_status       (w_status),
        .o_mean         (w_mean),
        .o_stddev       (w_stddev)
    );

    // the last program step holds until this load happens, so each item loads once
    assign w_out_load = (w_op == OP_OUT || w_op == OP_OUTEMPTY) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (w_op == OP_OUTEMPTY) begin
                o_mean_q24    <= '0;
                o_stddev_q24  <= '0;
                o_empty_error <= 1'b1;
            end else begin
                o_mean_q24    <= w_mean;
                o_stddev_q24  <= w_stddev;
                o_empty_error <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // an accepted item moves the sequencer off its idle step
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer stayed idle after accepting an item");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && o_out_valid) |-> i_out_ready)
        else $error("result register overwritten while pending");

    // empty runs report zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_error) |-> (o_mean_q24 == '0 && o_stddev_q24 == '0))
        else $error("empty result carries nonzero fields");
`endif

endmodule

`default_nettype wire
